// File: src/sqe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shadow quad extrusion package
// Shared widths, controller commands and register indexes.
// ----------------------------------------------------------------------------
package sqe_pkg;

    localparam int COORD_W    = 24;
    localparam int NORM_W     = 16;
    localparam int LEN_W      = 23;
    localparam int SLOT_W     = 9;
    localparam int SHADOW_W   = 10;
    localparam int DIFF_W     = 25;
    localparam int PROD_W     = 50;
    localparam int ROOT_W     = 31;
    localparam int RAD_W      = 62;
    localparam int REM_W      = 35;
    localparam int QUO_W      = 24;
    localparam int DREM_W     = 31;
    localparam int NUM_W      = 53;
    localparam int STEP_W     = 5;
    localparam int SQRT_STEPS = 31;
    localparam int DIV_STEPS  = 24;
    localparam int CFG_ADDR_W = 2;

    localparam logic [LEN_W-1:0] EXT_RESET = 23'd122880;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_LIGHT_X,
        CFG_LIGHT_Y,
        CFG_EXTRUDE_LEN
    } cfg_idx_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_DOT_X,
        OP_DOT_Y,
        OP_DOT_SUM,
        OP_SETUP,
        OP_SQ_X,
        OP_SQ_Y,
        OP_SQ_SUM,
        OP_SQRT,
        OP_MULP,
        OP_DIV_INIT,
        OP_DIV,
        OP_STORE,
        OP_FAR_ZERO,
        OP_LOAD_QUAD,
        OP_LOAD_SKIP
    } op_t;

    typedef struct packed {
        op_t  op;
        logic ep;
        logic comp;
    } cmd_t;

    typedef struct packed {
        logic facing;
        logic m_zero;
        logic out_full;
    } status_t;

endpackage

// File: src/sqe_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shadow quad extrusion controller
// Sequences the facing test, the square roots and the divisions of one wall.
// ----------------------------------------------------------------------------
module sqe_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  sqe_pkg::status_t status,
    output sqe_pkg::cmd_t    cmd
);
    import sqe_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DOT_X,
        S_DOT_Y,
        S_DOT_SUM,
        S_DECIDE,
        S_SETUP,
        S_SQ_X,
        S_SQ_Y,
        S_SQ_SUM,
        S_SQRT,
        S_CHECK,
        S_MULP,
        S_DIV_INIT,
        S_DIV,
        S_STORE,
        S_FAR_ZERO,
        S_FINISH
    } state_t;

    state_t              state_reg;
    logic [STEP_W-1:0]   cnt_reg;
    logic                ep_reg;
    logic                comp_reg;
    logic                facing_reg;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd.ep   = ep_reg;
        cmd.comp = comp_reg;
        unique case (state_reg)
            S_DOT_X:    cmd.op = OP_DOT_X;
            S_DOT_Y:    cmd.op = OP_DOT_Y;
            S_DOT_SUM:  cmd.op = OP_DOT_SUM;
            S_SETUP:    cmd.op = OP_SETUP;
            S_SQ_X:     cmd.op = OP_SQ_X;
            S_SQ_Y:     cmd.op = OP_SQ_Y;
            S_SQ_SUM:   cmd.op = OP_SQ_SUM;
            S_SQRT:     cmd.op = OP_SQRT;
            S_MULP:     cmd.op = OP_MULP;
            S_DIV_INIT: cmd.op = OP_DIV_INIT;
            S_DIV:      cmd.op = OP_DIV;
            S_STORE:    cmd.op = OP_STORE;
            S_FAR_ZERO: cmd.op = OP_FAR_ZERO;
            S_FINISH:
            begin
                if (status.out_full)
                    cmd.op = OP_NOP;
                else if (facing_reg)
                    cmd.op = OP_LOAD_QUAD;
                else
                    cmd.op = OP_LOAD_SKIP;
            end
            default:    cmd.op = OP_NOP;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            ep_reg     <= 1'b0;
            comp_reg   <= 1'b0;
            facing_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                        state_reg <= S_DOT_X;
                end
                S_DOT_X:   state_reg <= S_DOT_Y;
                S_DOT_Y:   state_reg <= S_DOT_SUM;
                S_DOT_SUM: state_reg <= S_DECIDE;
                S_DECIDE:
                begin
                    facing_reg <= status.facing;
                    ep_reg     <= 1'b0;
                    state_reg  <= status.facing ? S_SETUP : S_FINISH;
                end
                S_SETUP:   state_reg <= S_SQ_X;
                S_SQ_X:    state_reg <= S_SQ_Y;
                S_SQ_Y:    state_reg <= S_SQ_SUM;
                S_SQ_SUM:
                begin
                    cnt_reg   <= STEP_W'(SQRT_STEPS - 1);
                    state_reg <= S_SQRT;
                end
                S_SQRT:
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == '0)
                        state_reg <= S_CHECK;
                end
                S_CHECK:
                begin
                    comp_reg  <= 1'b0;
                    state_reg <= status.m_zero ? S_FAR_ZERO : S_MULP;
                end
                S_MULP:    state_reg <= S_DIV_INIT;
                S_DIV_INIT:
                begin
                    cnt_reg   <= STEP_W'(DIV_STEPS - 1);
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == '0)
                        state_reg <= S_STORE;
                end
                S_STORE:
                begin
                    if (!comp_reg)
                    begin
                        comp_reg  <= 1'b1;
                        state_reg <= S_MULP;
                    end
                    else if (!ep_reg)
                    begin
                        ep_reg    <= 1'b1;
                        state_reg <= S_SETUP;
                    end
                    else
                        state_reg <= S_FINISH;
                end
                S_FAR_ZERO:
                begin
                    if (!ep_reg)
                    begin
                        ep_reg    <= 1'b1;
                        state_reg <= S_SETUP;
                    end
                    else
                        state_reg <= S_FINISH;
                end
                S_FINISH:
                begin
                    if (!status.out_full)
                        state_reg <= S_IDLE;
                end
                default:   state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// File: src/sqe_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shadow quad extrusion datapath
// Shared multiplier, bit-pair square root, restoring divider and result register.
// ----------------------------------------------------------------------------
module sqe_datapath
#(
    parameter int MAX_QUADS = 512
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  sqe_pkg::cmd_t                         cmd,
    output sqe_pkg::status_t                      status,
    input  logic                                  cfg_we,
    input  logic [sqe_pkg::CFG_ADDR_W-1:0]        cfg_addr,
    input  logic [sqe_pkg::COORD_W-1:0]           cfg_wdata,
    input  logic                                  in_accept,
    input  logic signed [sqe_pkg::COORD_W-1:0]    in_e1x,
    input  logic signed [sqe_pkg::COORD_W-1:0]    in_e1y,
    input  logic signed [sqe_pkg::COORD_W-1:0]    in_e2x,
    input  logic signed [sqe_pkg::COORD_W-1:0]    in_e2y,
    input  logic signed [sqe_pkg::NORM_W-1:0]     in_nx,
    input  logic signed [sqe_pkg::NORM_W-1:0]     in_ny,
    input  logic                                  in_last,
    input  logic                                  out_ready,
    output logic                                  out_valid,
    output logic                                  emitted,
    output logic [sqe_pkg::SLOT_W-1:0]            quad_slot,
    output logic [sqe_pkg::SHADOW_W-1:0]          shadows_so_far,
    output logic signed [sqe_pkg::COORD_W-1:0]    near1_x,
    output logic signed [sqe_pkg::COORD_W-1:0]    near1_y,
    output logic signed [sqe_pkg::COORD_W-1:0]    near2_x,
    output logic signed [sqe_pkg::COORD_W-1:0]    near2_y,
    output logic signed [sqe_pkg::COORD_W-1:0]    far1_x,
    output logic signed [sqe_pkg::COORD_W-1:0]    far1_y,
    output logic signed [sqe_pkg::COORD_W-1:0]    far2_x,
    output logic signed [sqe_pkg::COORD_W-1:0]    far2_y
);
    import sqe_pkg::*;

    localparam int CNT_W = $clog2(MAX_QUADS + 1);

    logic signed [COORD_W-1:0] light_x_reg, light_y_reg;
    logic [LEN_W-1:0]          ext_reg;
    logic [CNT_W-1:0]          count_reg;

    logic signed [COORD_W-1:0] e1x_reg, e1y_reg, e2x_reg, e2y_reg;
    logic signed [NORM_W-1:0]  nx_reg, ny_reg;
    logic                      last_reg;

    logic [COORD_W-1:0]        ax_reg, ay_reg;
    logic                      xneg_reg, yneg_reg;
    logic signed [PROD_W-1:0]  prod_reg, acc_reg;
    logic [RAD_W-1:0]          rad_reg;
    logic [REM_W-1:0]          rem_reg;
    logic [ROOT_W-1:0]         root_reg;
    logic [DREM_W-1:0]         drem_reg;
    logic [QUO_W-1:0]          dq_reg;
    logic signed [COORD_W-1:0] f1x_reg, f1y_reg, f2x_reg, f2y_reg;

    logic                      out_valid_reg, emitted_reg;
    logic [SLOT_W-1:0]         slot_reg;
    logic [SHADOW_W-1:0]       shadows_reg;
    logic signed [COORD_W-1:0] n1x_reg, n1y_reg, n2x_reg, n2y_reg;
    logic signed [COORD_W-1:0] o1x_reg, o1y_reg, o2x_reg, o2y_reg;

    // Combinational helpers
    logic signed [DIFF_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0]  mul_p, acc_sum;
    logic signed [COORD_W-1:0] ep_x, ep_y, ep_c;
    logic signed [DIFF_W-1:0]  dx, dy;
    logic [DIFF_W-1:0]         abs_x, abs_y;
    logic [REM_W-1:0]          rem_sh, trial;
    logic [NUM_W-1:0]          num;
    logic [DREM_W:0]           dt, dm;
    logic signed [COORD_W+1:0] push, far_sum;
    logic signed [COORD_W-1:0] far_sat;
    logic                      c_neg;
    logic [31:0]               count_ext, count_inc_ext;
    logic [CNT_W-1:0]          count_inc;

    assign ep_x = cmd.ep ? e2x_reg : e1x_reg;
    assign ep_y = cmd.ep ? e2y_reg : e1y_reg;
    assign dx   = DIFF_W'(ep_x) - DIFF_W'(light_x_reg);
    assign dy   = DIFF_W'(ep_y) - DIFF_W'(light_y_reg);
    assign abs_x = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
    assign abs_y = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);

    always_comb
    begin
        case (cmd.op)
            OP_DOT_X:
            begin
                mul_a = DIFF_W'(nx_reg);
                mul_b = DIFF_W'(light_x_reg) - DIFF_W'(e1x_reg);
            end
            OP_DOT_Y:
            begin
                mul_a = DIFF_W'(ny_reg);
                mul_b = DIFF_W'(light_y_reg) - DIFF_W'(e1y_reg);
            end
            OP_SQ_X:
            begin
                mul_a = {1'b0, ax_reg};
                mul_b = {1'b0, ax_reg};
            end
            OP_SQ_Y:
            begin
                mul_a = {1'b0, ay_reg};
                mul_b = {1'b0, ay_reg};
            end
            OP_MULP:
            begin
                mul_a = {1'b0, (cmd.comp ? ay_reg : ax_reg)};
                mul_b = {2'b00, ext_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p   = PROD_W'(mul_a * mul_b);
    assign acc_sum = acc_reg + prod_reg;

    // Square root: bring down two radicand bits, try (root * 4 + 1).
    assign rem_sh = {rem_reg[REM_W-3:0], rad_reg[RAD_W-1:RAD_W-2]};
    assign trial  = {{(REM_W-ROOT_W-2){1'b0}}, root_reg, 2'b01};

    // Rounded numerator: component * length * 64 + m / 2.
    assign num = {prod_reg[NUM_W-7:0], 6'b0} + NUM_W'(root_reg[ROOT_W-1:1]);
    assign dt  = {drem_reg, dq_reg[QUO_W-1]};
    assign dm  = {1'b0, root_reg};

    assign ep_c    = cmd.comp ? ep_y : ep_x;
    assign c_neg   = cmd.comp ? yneg_reg : xneg_reg;
    assign push    = c_neg ? -$signed({2'b00, dq_reg}) : $signed({2'b00, dq_reg});
    assign far_sum = (COORD_W+2)'(ep_c) + push;

    always_comb
    begin
        if (far_sum[COORD_W+1:COORD_W-1] == 3'b000 || far_sum[COORD_W+1:COORD_W-1] == 3'b111)
            far_sat = far_sum[COORD_W-1:0];
        else if (far_sum[COORD_W+1])
            far_sat = {1'b1, {(COORD_W-1){1'b0}}};
        else
            far_sat = {1'b0, {(COORD_W-1){1'b1}}};
    end

    assign count_inc     = count_reg + 1'b1;
    assign count_ext     = {{(32-CNT_W){1'b0}}, count_reg};
    assign count_inc_ext = {{(32-CNT_W){1'b0}}, count_inc};

    assign status.facing   = !acc_reg[PROD_W-1] && (count_reg < CNT_W'(MAX_QUADS));
    assign status.m_zero   = (root_reg == '0);
    assign status.out_full = out_valid_reg && !out_ready;

    // Control state: configuration, quad count, output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            light_x_reg   <= '0;
            light_y_reg   <= '0;
            ext_reg       <= EXT_RESET;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    CFG_LIGHT_X:     light_x_reg <= cfg_wdata;
                    CFG_LIGHT_Y:     light_y_reg <= cfg_wdata;
                    CFG_EXTRUDE_LEN: ext_reg     <= cfg_wdata[LEN_W-1:0];
                    default:         ;
                endcase
            end
            if (cmd.op == OP_LOAD_QUAD || cmd.op == OP_LOAD_SKIP)
            begin
                out_valid_reg <= 1'b1;
                if (last_reg)
                    count_reg <= '0;
                else if (cmd.op == OP_LOAD_QUAD)
                    count_reg <= count_inc;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            e1x_reg  <= in_e1x;
            e1y_reg  <= in_e1y;
            e2x_reg  <= in_e2x;
            e2y_reg  <= in_e2y;
            nx_reg   <= in_nx;
            ny_reg   <= in_ny;
            last_reg <= in_last;
        end

        case (cmd.op)
            OP_DOT_X, OP_SQ_X, OP_MULP:
                prod_reg <= mul_p;
            OP_DOT_Y, OP_SQ_Y:
            begin
                acc_reg  <= prod_reg;
                prod_reg <= mul_p;
            end
            OP_DOT_SUM:
                acc_reg <= acc_sum;
            OP_SETUP:
            begin
                ax_reg   <= abs_x[COORD_W-1:0];
                ay_reg   <= abs_y[COORD_W-1:0];
                xneg_reg <= dx[DIFF_W-1];
                yneg_reg <= dy[DIFF_W-1];
            end
            OP_SQ_SUM:
            begin
                rad_reg  <= {acc_sum[RAD_W-13:0], 12'b0};
                rem_reg  <= '0;
                root_reg <= '0;
            end
            OP_SQRT:
            begin
                rad_reg <= {rad_reg[RAD_W-3:0], 2'b00};
                if (rem_sh >= trial)
                begin
                    rem_reg  <= rem_sh - trial;
                    root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= rem_sh;
                    root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
                end
            end
            OP_DIV_INIT:
            begin
                drem_reg <= DREM_W'(num[NUM_W-1:QUO_W]);
                dq_reg   <= num[QUO_W-1:0];
            end
            OP_DIV:
            begin
                if (dt >= dm)
                begin
                    drem_reg <= DREM_W'(dt - dm);
                    dq_reg   <= {dq_reg[QUO_W-2:0], 1'b1};
                end
                else
                begin
                    drem_reg <= dt[DREM_W-1:0];
                    dq_reg   <= {dq_reg[QUO_W-2:0], 1'b0};
                end
            end
            OP_STORE:
            begin
                unique case ({cmd.ep, cmd.comp})
                    2'b00:   f1x_reg <= far_sat;
                    2'b01:   f1y_reg <= far_sat;
                    2'b10:   f2x_reg <= far_sat;
                    default: f2y_reg <= far_sat;
                endcase
            end
            OP_FAR_ZERO:
            begin
                if (cmd.ep)
                begin
                    f2x_reg <= e2x_reg;
                    f2y_reg <= e2y_reg;
                end
                else
                begin
                    f1x_reg <= e1x_reg;
                    f1y_reg <= e1y_reg;
                end
            end
            OP_LOAD_QUAD:
            begin
                emitted_reg <= 1'b1;
                slot_reg    <= count_ext[SLOT_W-1:0];
                shadows_reg <= count_inc_ext[SHADOW_W-1:0];
                n1x_reg     <= e1x_reg;
                n1y_reg     <= e1y_reg;
                n2x_reg     <= e2x_reg;
                n2y_reg     <= e2y_reg;
                o1x_reg     <= f1x_reg;
                o1y_reg     <= f1y_reg;
                o2x_reg     <= f2x_reg;
                o2y_reg     <= f2y_reg;
            end
            OP_LOAD_SKIP:
            begin
                emitted_reg <= 1'b0;
                slot_reg    <= '0;
                shadows_reg <= count_ext[SHADOW_W-1:0];
                n1x_reg     <= '0;
                n1y_reg     <= '0;
                n2x_reg     <= '0;
                n2y_reg     <= '0;
                o1x_reg     <= '0;
                o1y_reg     <= '0;
                o2x_reg     <= '0;
                o2y_reg     <= '0;
            end
            default: ;
        endcase
    end

    assign out_valid      = out_valid_reg;
    assign emitted        = emitted_reg;
    assign quad_slot      = slot_reg;
    assign shadows_so_far = shadows_reg;
    assign near1_x        = n1x_reg;
    assign near1_y        = n1y_reg;
    assign near2_x        = n2x_reg;
    assign near2_y        = n2y_reg;
    assign far1_x         = o1x_reg;
    assign far1_y         = o1y_reg;
    assign far2_x         = o2x_reg;
    assign far2_y         = o2y_reg;

endmodule

// File: src/shadow_quad_extrusion_2d_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shadow quad extrusion, 2D
// Culls back-facing walls and extrudes facing ones into shadow quads.
// ----------------------------------------------------------------------------
// Channel   Dir  Contents
// s_axis    in   wall endpoints and normal in tdata, end of list in tlast
// m_axis    out  slot, count, near and far corners in tdata, emitted in tuser
// cfg       in   light_x (0), light_y (1), extrude_length (2)
//
// A facing wall is worked per endpoint with two squares, a 31-step square
// root and two 24-step divisions on one shared multiplier, square root unit
// and divider. A skipped wall goes straight to the result.
// s_axis_tready is high only while the block is idle; a finished result waits
// in the output register, and the block stalls before loading the next one.
// Reset clears the quad count and restores the light and length defaults.
// ----------------------------------------------------------------------------
module shadow_quad_extrusion_2d_unit
#(
    parameter int MAX_QUADS = 512
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [1:0]    cfg_addr,
    input  logic [23:0]   cfg_wdata,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // end1_x, end1_y, end2_x, end2_y, wall_normal_x, wall_normal_y
    input  logic [127:0]  s_axis_tdata,
    input  logic          s_axis_tlast,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // quad_slot, shadows_so_far, near1_x, near1_y, near2_x, near2_y,
    // far1_x, far1_y, far2_x, far2_y, zero pad
    output logic [215:0]  m_axis_tdata,
    // emitted
    output logic [0:0]    m_axis_tuser
);
    import sqe_pkg::*;

    cmd_t    cmd;
    status_t status;
    logic    in_accept;
    logic    emitted;
    logic [SLOT_W-1:0]         quad_slot;
    logic [SHADOW_W-1:0]       shadows_so_far;
    logic signed [COORD_W-1:0] near1_x, near1_y, near2_x, near2_y;
    logic signed [COORD_W-1:0] far1_x, far1_y, far2_x, far2_y;

    assign in_accept = s_axis_tvalid && s_axis_tready;

    sqe_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    sqe_datapath #(.MAX_QUADS(MAX_QUADS)) u_datapath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg_we         (cfg_we),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .in_accept      (in_accept),
        .in_e1x         (s_axis_tdata[23:0]),
        .in_e1y         (s_axis_tdata[47:24]),
        .in_e2x         (s_axis_tdata[71:48]),
        .in_e2y         (s_axis_tdata[95:72]),
        .in_nx          (s_axis_tdata[111:96]),
        .in_ny          (s_axis_tdata[127:112]),
        .in_last        (s_axis_tlast),
        .out_ready      (m_axis_tready),
        .out_valid      (m_axis_tvalid),
        .emitted        (emitted),
        .quad_slot      (quad_slot),
        .shadows_so_far (shadows_so_far),
        .near1_x        (near1_x),
        .near1_y        (near1_y),
        .near2_x        (near2_x),
        .near2_y        (near2_y),
        .far1_x         (far1_x),
        .far1_y         (far1_y),
        .far2_x         (far2_x),
        .far2_y         (far2_y)
    );

    assign m_axis_tdata = {5'b0, far2_y, far2_x, far1_y, far1_x,
                           near2_y, near2_x, near1_y, near1_x,
                           shadows_so_far, quad_slot};
    assign m_axis_tuser = emitted;

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shadow quad extrusion unit testbench
// Drives wall segments into the unit and compares every shadow quad with a
// behavioral model of culling, count capping and fixed-point extrusion.
// ----------------------------------------------------------------------------
module tb;
    import sqe_pkg::*;

    localparam int MAX_Q      = 512;
    localparam int CYCLE_CAP  = 3000000;
    localparam int DRAIN_WAIT = 400;

    typedef struct packed {
        logic                      emitted;
        logic [SLOT_W-1:0]         slot;
        logic [SHADOW_W-1:0]       so_far;
        logic signed [COORD_W-1:0] n1x, n1y, n2x, n2y;
        logic signed [COORD_W-1:0] f1x, f1y, f2x, f2y;
    } quad_t;

    logic         clk;
    logic         rst_n;
    logic         cfg_we;
    logic [1:0]   cfg_addr;
    logic [23:0]  cfg_wdata;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata;
    logic         s_axis_tlast;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [215:0] m_axis_tdata;
    logic [0:0]   m_axis_tuser;

    shadow_quad_extrusion_2d_unit #(.MAX_QUADS(MAX_Q)) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Model state
    logic signed [COORD_W-1:0] lamp_x, lamp_y;
    logic [LEN_W-1:0]          push_len;
    int unsigned               quads_for_light;

    quad_t quads_due[$];
    int    errors;
    int    cycles;
    int    send_idle_pct;
    int    recv_idle_pct;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_CAP)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    function automatic logic [63:0] root_of(logic [63:0] s);
        logic [63:0] r;
        logic [63:0] b;
        r = 64'd0;
        b = 64'd1 << 62;
        while (b > s)
            b = b >> 2;
        while (b != 0)
        begin
            if (s >= r + b)
            begin
                s = s - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic signed [COORD_W-1:0] clamp_coord(longint v);
        if (v > 8388607)
            return 24'sh7fffff;
        if (v < -8388608)
            return 24'sh800000;
        return v[COORD_W-1:0];
    endfunction

    // Pushes one endpoint away from the light along its unit direction.
    task automatic far_corner(input logic signed [COORD_W-1:0] ex, ey,
                              output logic signed [COORD_W-1:0] fx, fy);
        longint dx, dy, px, py;
        logic [63:0] ax, ay, m, nx, ny;
        dx = longint'(ex) - longint'(lamp_x);
        dy = longint'(ey) - longint'(lamp_y);
        ax = dx < 0 ? -dx : dx;
        ay = dy < 0 ? -dy : dy;
        m  = root_of((ax * ax + ay * ay) << 12);
        px = 0;
        py = 0;
        if (m != 0)
        begin
            nx = ax * push_len * 64;
            ny = ay * push_len * 64;
            px = (nx + (m >> 1)) / m;
            py = (ny + (m >> 1)) / m;
            if (dx < 0)
                px = -px;
            if (dy < 0)
                py = -py;
        end
        fx = clamp_coord(longint'(ex) + px);
        fy = clamp_coord(longint'(ey) + py);
    endtask

    task automatic predict_quad(input logic [127:0] wall, input logic last);
        logic signed [COORD_W-1:0] e1x, e1y, e2x, e2y;
        logic signed [NORM_W-1:0]  nx, ny;
        longint dp;
        quad_t q;
        e1x = wall[23:0];
        e1y = wall[47:24];
        e2x = wall[71:48];
        e2y = wall[95:72];
        nx  = wall[111:96];
        ny  = wall[127:112];
        dp  = longint'(nx) * (longint'(lamp_x) - longint'(e1x))
            + longint'(ny) * (longint'(lamp_y) - longint'(e1y));
        q = '0;
        if (dp >= 0 && quads_for_light < MAX_Q)
        begin
            q.emitted = 1'b1;
            q.slot = quads_for_light[SLOT_W-1:0];
            quads_for_light++;
            q.n1x = e1x;
            q.n1y = e1y;
            q.n2x = e2x;
            q.n2y = e2y;
            far_corner(e1x, e1y, q.f1x, q.f1y);
            far_corner(e2x, e2y, q.f2x, q.f2y);
        end
        q.so_far = quads_for_light[SHADOW_W-1:0];
        if (last)
            quads_for_light = 0;
        quads_due.push_back(q);
    endtask

    // Result checker
    initial
    begin
        quad_t got, want;
        errors = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
            begin
                got.emitted = m_axis_tuser[0];
                got.slot    = m_axis_tdata[8:0];
                got.so_far  = m_axis_tdata[18:9];
                got.n1x     = m_axis_tdata[42:19];
                got.n1y     = m_axis_tdata[66:43];
                got.n2x     = m_axis_tdata[90:67];
                got.n2y     = m_axis_tdata[114:91];
                got.f1x     = m_axis_tdata[138:115];
                got.f1y     = m_axis_tdata[162:139];
                got.f2x     = m_axis_tdata[186:163];
                got.f2y     = m_axis_tdata[210:187];
                if (quads_due.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result %h", $time, got);
                end
                else
                begin
                    want = quads_due.pop_front();
                    if (got != want)
                    begin
                        errors++;
                        $display("%0t: mismatch", $time);
                        $display("  expected e=%b slot=%0d cnt=%0d n=%0d,%0d %0d,%0d",
                                 want.emitted, want.slot, want.so_far,
                                 want.n1x, want.n1y, want.n2x, want.n2y);
                        $display("    far %0d,%0d %0d,%0d",
                                 want.f1x, want.f1y, want.f2x, want.f2y);
                        $display("  actual   e=%b slot=%0d cnt=%0d n=%0d,%0d %0d,%0d",
                                 got.emitted, got.slot, got.so_far,
                                 got.n1x, got.n1y, got.n2x, got.n2y);
                        $display("    far %0d,%0d %0d,%0d",
                                 got.f1x, got.f1y, got.f2x, got.f2y);
                    end
                end
            end
        end
    end

    // Receiver stalls
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_wall(input logic [127:0] wall, input logic last);
        while ($urandom_range(99) < send_idle_pct)
            @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= wall;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_quad(wall, last);
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        // The block stays busy after taking a wall, so the next transaction starts
        // on a later falling edge.
        @(negedge clk);
    endtask

    task automatic wait_drained();
        while (quads_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [23:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_LIGHT_X:     lamp_x = value;
            CFG_LIGHT_Y:     lamp_y = value;
            CFG_EXTRUDE_LEN: push_len = value[LEN_W-1:0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    function automatic logic [127:0] make_wall(logic [23:0] x1, y1, x2, y2,
                                                logic [15:0] nx, ny);
        return {ny, nx, y2, x2, y1, x1};
    endfunction

    // Endpoints near the light with a normal pointing at it, mostly.
    function automatic logic [127:0] rand_wall();
        logic [23:0] x1, y1, x2, y2;
        logic [15:0] nx, ny;
        int spread;
        spread = 1 << $urandom_range(23, 4);
        x1 = 24'(lamp_x + $urandom_range(2 * spread) - spread);
        y1 = 24'(lamp_y + $urandom_range(2 * spread) - spread);
        x2 = 24'(lamp_x + $urandom_range(2 * spread) - spread);
        y2 = 24'(lamp_y + $urandom_range(2 * spread) - spread);
        if ($urandom_range(9) == 0)
        begin
            x1 = 24'($urandom);
            y1 = 24'($urandom);
            x2 = 24'($urandom);
            y2 = 24'($urandom);
        end
        nx = 16'($urandom);
        ny = 16'($urandom);
        if ($urandom_range(9) < 6)
        begin
            nx = ($signed(lamp_x - x1) < 0) ? 16'(-16'sd16384 + $urandom_range(300))
                                             : 16'(16'sd16384 - $urandom_range(300));
            ny = ($signed(lamp_y - y1) < 0) ? 16'(-16'sd16384 + $urandom_range(300))
                                             : 16'(16'sd16384 - $urandom_range(300));
        end
        if ($urandom_range(19) == 0)
        begin
            x1 = lamp_x;
            y1 = lamp_y;
        end
        return make_wall(x1, y1, x2, y2, nx, ny);
    endfunction

    task automatic test_directed();
        // Default light at origin and default extrusion length.
        send_wall(make_wall(24'h001000, 24'h002000, 24'h003000, 24'h000000,
                            16'hc000, 16'h0000), 1'b0);
        // Back-facing wall.
        send_wall(make_wall(24'h001000, 24'h000000, 24'h001000, 24'h001000,
                            16'h4000, 16'h0000), 1'b0);
        // Dot exactly zero counts as facing.
        send_wall(make_wall(24'h001000, 24'h000000, 24'hfff000, 24'h000000,
                            16'h0000, 16'h4000), 1'b0);
        // Endpoint on the light gets no push.
        send_wall(make_wall(24'h000000, 24'h000000, 24'h005000, 24'h005000,
                            16'h1234, 16'h1234), 1'b0);
        // Extreme corners saturate.
        send_wall(make_wall(24'h7fffff, 24'h800000, 24'h800000, 24'h7fffff,
                            16'h8000, 16'h7fff), 1'b0);
        send_wall(make_wall(24'h7fffff, 24'h7fffff, 24'h800000, 24'h800000,
                            16'h8000, 16'h8000), 1'b1);
        send_wall(make_wall(24'h800000, 24'h800000, 24'h000001, 24'hffffff,
                            16'h7fff, 16'h7fff), 1'b1);
        wait_drained();
        write_reg(CFG_LIGHT_X, 24'h800000);
        write_reg(CFG_LIGHT_Y, 24'h7fffff);
        write_reg(CFG_EXTRUDE_LEN, 24'hffffff);
        send_wall(make_wall(24'h7fffff, 24'h800000, 24'h000000, 24'h000000,
                            16'h8000, 16'h7fff), 1'b0);
        send_wall(make_wall(24'h800000, 24'h7fffff, 24'h123456, 24'hedcba9,
                            16'h5555, 16'haaaa), 1'b1);
        wait_drained();
        write_reg(CFG_LIGHT_X, 24'h7fffff);
        write_reg(CFG_LIGHT_Y, 24'h800000);
        write_reg(CFG_EXTRUDE_LEN, 24'h000000);
        send_wall(make_wall(24'h000000, 24'h000000, 24'h7fffff, 24'h7fffff,
                            16'h7fff, 16'h8000), 1'b1);
        wait_drained();
    endtask

    // Fill the list past the cap so that facing walls get dropped.
    task automatic test_count_cap();
        write_reg(CFG_LIGHT_X, 24'h000000);
        write_reg(CFG_LIGHT_Y, 24'h000000);
        write_reg(CFG_EXTRUDE_LEN, 24'd4096);
        for (int i = 0; i < MAX_Q + 4; i++)
            send_wall(make_wall(24'(24'h001000 + i), 24'h000100, 24'h001000, 24'h002000,
                                16'hc000, 16'h0000), i == MAX_Q + 3);
        send_wall(make_wall(24'h001000, 24'h000000, 24'h002000, 24'h000000,
                            16'hc000, 16'h0000), 1'b1);
        wait_drained();
    endtask

    task automatic test_random(input int n_walls);
        int left;
        left = n_walls;
        while (left > 0)
        begin
            wait_drained();
            write_reg(CFG_LIGHT_X, $urandom_range(9) == 0 ? 24'($urandom)
                                                          : 24'($urandom_range(65535) - 32768));
            write_reg(CFG_LIGHT_Y, $urandom_range(9) == 0 ? 24'($urandom)
                                                          : 24'($urandom_range(65535) - 32768));
            write_reg(CFG_EXTRUDE_LEN, $urandom_range(3) == 0 ? 24'($urandom)
                                                             : 24'($urandom_range(409600)));
            for (int j = $urandom_range(40, 1); j > 0 && left > 0; j--)
            begin
                send_wall(rand_wall(), j == 1 || $urandom_range(15) == 0);
                left--;
            end
        end
        wait_drained();
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_addr      = '0;
        cfg_wdata     = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        lamp_x        = '0;
        lamp_y        = '0;
        push_len      = EXT_RESET;
        quads_for_light = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_count_cap();
        send_idle_pct = 12;
        recv_idle_pct = 82;
        test_random(350);
        send_idle_pct = 82;
        recv_idle_pct = 12;
        test_random(350);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(400);

        wait_drained();
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

// File: sim.f
src/sqe_pkg.sv
src/sqe_ctrl.sv
src/sqe_datapath.sv
src/shadow_quad_extrusion_2d_unit.sv
tb/tb.sv
